// ===== hw/rtl/emr_pkg.sv =====
// Package for the midpoint ellipse rasterizer: default widths, register
// indexes and the control struct between sequencer and pixel emitter.
// No dependencies.
package emr_pkg;

  localparam int RADIUS_BITS_DEF = 10;
  localparam int COORD_BITS_DEF  = 12;
  localparam int DEC_BITS        = 48;
  localparam int CFG_IDX_BITS    = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS_Y = 2'd3;

  typedef struct packed {
    logic valid;
    logic fin;
  } grp_ctl_t;

endpackage

// ===== hw/rtl/emr_cmd_if.sv =====
// Request channel of the ellipse rasterizer: one start/advance bit.
// Depends on nothing.
interface emr_cmd_if;
  logic valid;
  logic ready;
  logic start_req;

  modport source (output valid, output start_req, input ready);
  modport sink (input valid, input start_req, output ready);
endinterface

// ===== hw/rtl/emr_pix_if.sv =====
// Pixel channel of the ellipse rasterizer.
// Depends on emr_pkg for the default coordinate width.
interface emr_pix_if #(
  parameter int OUT_BITS = emr_pkg::COORD_BITS_DEF + 1
);
  logic                       valid;
  logic                       ready;
  logic signed [OUT_BITS-1:0] pixel_x;
  logic signed [OUT_BITS-1:0] pixel_y;
  logic                       last;
  logic                       done_res;

  modport source (output valid, output pixel_x, output pixel_y, output last,
                  output done_res, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input last,
                input done_res, output ready);
endinterface

// ===== hw/rtl/emr_cfg_if.sv =====
// Configuration write channel of the ellipse rasterizer.
// Depends on emr_pkg for the index width and default data width.
interface emr_cfg_if #(
  parameter int DATA_BITS = emr_pkg::COORD_BITS_DEF
);
  logic                              valid;
  logic                              ready;
  logic [emr_pkg::CFG_IDX_BITS-1:0]  index;
  logic [DATA_BITS-1:0]              data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/emr_mul.sv =====
// Shared unsigned multiplier of the ellipse rasterizer with a registered product.
// No package dependencies.
module emr_mul #(
  parameter int A_BITS = 20,
  parameter int B_BITS = 24
) (
  input  logic                     clk,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
  end

endmodule

// ===== hw/rtl/emr_emit.sv =====
// Pixel emitter: expands one point into its four mirrored pixels and holds
// each in an output register. Depends on emr_pkg and emr_pix_if.
module emr_emit #(
  parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  emr_pkg::grp_ctl_t             grp_ctl,
  input  logic [RADIUS_BITS:0]          grp_x,
  input  logic [RADIUS_BITS:0]          grp_y,
  input  logic signed [COORD_BITS-1:0]  center_x,
  input  logic signed [COORD_BITS-1:0]  center_y,
  output logic                          grp_ready,
  emr_pix_if.source                     pix
);

  localparam int POS_BITS = RADIUS_BITS + 1;
  localparam int OUT_BITS = COORD_BITS + 1;
  localparam int SUM_BITS = ((OUT_BITS > POS_BITS) ? OUT_BITS : POS_BITS) + 1;

  logic                  busy;
  logic [1:0]            cnt;
  logic [POS_BITS-1:0]   gx;
  logic [POS_BITS-1:0]   gy;
  logic                  gfin;
  logic [COORD_BITS-1:0] gcx;
  logic [COORD_BITS-1:0] gcy;
  logic                  out_valid;
  logic [OUT_BITS-1:0]   out_x;
  logic [OUT_BITS-1:0]   out_y;
  logic                  out_last;
  logic                  out_done;
  logic [SUM_BITS-1:0]   cx_ext;
  logic [SUM_BITS-1:0]   cy_ext;
  logic [SUM_BITS-1:0]   sum_x;
  logic [SUM_BITS-1:0]   sum_y;
  logic                  load;
  logic                  adv;

  assign grp_ready = !busy;
  assign load      = grp_ctl.valid && !busy;
  assign adv       = busy && (!out_valid || pix.ready);

  // Group order: (+x,+y), (+x,-y), (-x,+y), (-x,-y).
  always_comb begin
    cx_ext = SUM_BITS'($signed(gcx));
    cy_ext = SUM_BITS'($signed(gcy));
    sum_x  = cnt[1] ? (cx_ext - SUM_BITS'(gx)) : (cx_ext + SUM_BITS'(gx));
    sum_y  = cnt[0] ? (cy_ext - SUM_BITS'(gy)) : (cy_ext + SUM_BITS'(gy));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= 2'd0;
      out_valid <= 1'b0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
      if (pix.ready) begin
        out_valid <= 1'b0;
      end
    end else if (adv) begin
      out_valid <= 1'b1;
      cnt       <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      gx   <= grp_x;
      gy   <= grp_y;
      gfin <= grp_ctl.fin;
      gcx  <= center_x;
      gcy  <= center_y;
    end
    if (adv) begin
      out_x    <= sum_x[OUT_BITS-1:0];
      out_y    <= sum_y[OUT_BITS-1:0];
      out_last <= (cnt == 2'd3);
      out_done <= gfin;
    end
  end

  assign pix.valid    = out_valid;
  assign pix.pixel_x  = $signed(out_x);
  assign pix.pixel_y  = $signed(out_y);
  assign pix.last     = out_last;
  assign pix.done_res = out_done;

endmodule

// ===== hw/rtl/midpoint_ellipse_raster.sv =====
// Top level of the midpoint ellipse rasterizer: configuration registers,
// decision sequencer and datapath. Depends on emr_pkg, the channel
// interfaces, emr_mul and emr_emit.
//
//  channel | modport | payload                                | direction
//  --------+---------+----------------------------------------+----------
//  cfg     | sink    | index, data                            | in
//  cmd     | sink    | start_req                              | in
//  pix     | source  | pixel_x, pixel_y, last, done_res       | out
//
// A start request or an advance is worked through the sequencer states
// before its point is handed to the emitter, and the advance that crosses
// into the second region also passes the states that reload the decision;
// every product goes through the one shared multiplier. The emitter then
// drives one pixel per cycle when the pixel channel is not stalled, while the
// next request is already being worked on.
// An advance after the ellipse has finished is absorbed in the idle state and
// yields no pixels. Reset (synchronous, active high) clears the walker to the
// finished state. A stalled pixel channel holds the emitter and, through it,
// the hand-off of the following point.
module midpoint_ellipse_raster #(
  parameter int RADIUS_BITS = emr_pkg::RADIUS_BITS_DEF,
  parameter int COORD_BITS  = emr_pkg::COORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  emr_cfg_if.sink   cfg,
  emr_cmd_if.sink   cmd,
  emr_pix_if.source pix
);

  localparam int POS_BITS = RADIUS_BITS + 1;
  localparam int MA_BITS  = 2 * RADIUS_BITS;
  localparam int MB_BITS  = 2 * RADIUS_BITS + 4;
  localparam int PB_BITS  = MA_BITS + MB_BITS;
  localparam int DB       = emr_pkg::DEC_BITS;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_SQY  = 4'd1;
  localparam logic [3:0] ST_BR   = 4'd2;
  localparam logic [3:0] ST_INIT = 4'd3;
  localparam logic [3:0] ST_CMP1 = 4'd4;
  localparam logic [3:0] ST_CMP2 = 4'd5;
  localparam logic [3:0] ST_R2A  = 4'd6;
  localparam logic [3:0] ST_R2B  = 4'd7;
  localparam logic [3:0] ST_R2C  = 4'd8;
  localparam logic [3:0] ST_R2D  = 4'd9;
  localparam logic [3:0] ST_R2E  = 4'd10;
  localparam logic [3:0] ST_UPD  = 4'd11;
  localparam logic [3:0] ST_M1   = 4'd12;
  localparam logic [3:0] ST_A1   = 4'd13;
  localparam logic [3:0] ST_A2   = 4'd14;
  localparam logic [3:0] ST_GRP  = 4'd15;

  // Configuration registers, read live by the sequencer.
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic [RADIUS_BITS-1:0]       radius_x;
  logic [RADIUS_BITS-1:0]       radius_y;

  // Walker state.
  logic [3:0]          state;
  logic                is_start;
  logic [POS_BITS-1:0] cur_x;
  logic [POS_BITS-1:0] cur_y;
  logic [DB-1:0]       decision;
  logic                region_two;
  logic                finished;
  logic [MA_BITS-1:0]  rx2;
  logic [MA_BITS-1:0]  ry2;
  logic [PB_BITS-1:0]  cmp_lhs;
  logic                use_ry2x;
  logic                use_rx2y;

  // Shared multiplier.
  logic [MA_BITS-1:0]  mul_a;
  logic [MB_BITS-1:0]  mul_b;
  logic [PB_BITS-1:0]  prod;
  logic [DB-1:0]       prod_dec;
  logic [POS_BITS:0]   x_odd;
  logic [POS_BITS-1:0] y_dec;

  emr_pkg::grp_ctl_t   grp_ctl;
  logic                grp_ready;
  logic                cmd_fire;
  logic                dec_neg;
  logic                dec_pos;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x <= '0;
      center_y <= '0;
      radius_x <= '0;
      radius_y <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        emr_pkg::CFG_CENTER_X: center_x <= $signed(cfg.data[COORD_BITS-1:0]);
        emr_pkg::CFG_CENTER_Y: center_y <= $signed(cfg.data[COORD_BITS-1:0]);
        emr_pkg::CFG_RADIUS_X: radius_x <= cfg.data[RADIUS_BITS-1:0];
        emr_pkg::CFG_RADIUS_Y: radius_y <= cfg.data[RADIUS_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign cmd.ready = (state == ST_IDLE);
  assign cmd_fire  = cmd.valid && cmd.ready;

  // (2x+1) and (y-1) feed the squares of the region-2 starting decision.
  assign x_odd    = {cur_x, 1'b1};
  assign y_dec    = cur_y - POS_BITS'(1);
  assign prod_dec = DB'(prod);
  assign dec_neg  = decision[DB-1];
  assign dec_pos  = !dec_neg && (decision != '0);

  // Operand selection: each state issues at most one product, which is
  // available in the prod register during the following state.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_IDLE: begin
        mul_a = MA_BITS'(radius_x);
        mul_b = MB_BITS'(radius_x);
      end
      ST_SQY: begin
        mul_a = MA_BITS'(radius_y);
        mul_b = MB_BITS'(radius_y);
      end
      ST_BR: begin
        if (is_start) begin
          mul_a = rx2;
          mul_b = MB_BITS'(radius_y);
        end else begin
          // ry^2 is still in the product register here.
          mul_a = prod[MA_BITS-1:0];
          mul_b = MB_BITS'(cur_x);
        end
      end
      ST_CMP1: begin
        mul_a = rx2;
        mul_b = MB_BITS'(cur_y);
      end
      ST_CMP2: begin
        mul_a = MA_BITS'(x_odd);
        mul_b = MB_BITS'(x_odd);
      end
      ST_R2A: begin
        mul_a = ry2;
        mul_b = prod[MB_BITS-1:0];
      end
      ST_R2B: begin
        mul_a = MA_BITS'(y_dec);
        mul_b = MB_BITS'(y_dec);
      end
      ST_R2C: begin
        mul_a = rx2;
        mul_b = prod[MB_BITS-1:0];
      end
      ST_R2D: begin
        mul_a = rx2;
        mul_b = MB_BITS'(ry2);
      end
      ST_M1: begin
        mul_a = ry2;
        mul_b = MB_BITS'(cur_x);
      end
      ST_A1: begin
        mul_a = rx2;
        mul_b = MB_BITS'(cur_y);
      end
      default: ;
    endcase
  end

  emr_mul #(
    .A_BITS(MA_BITS),
    .B_BITS(MB_BITS)
  ) u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      is_start   <= 1'b0;
      cur_x      <= '0;
      cur_y      <= '0;
      decision   <= '0;
      region_two <= 1'b0;
      finished   <= 1'b1;
      use_ry2x   <= 1'b0;
      use_rx2y   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd_fire) begin
            is_start <= cmd.start_req;
            // An advance past the end is absorbed here with no pixels.
            if (cmd.start_req || !finished) begin
              state <= ST_SQY;
            end
          end
        end
        ST_SQY: begin
          state <= ST_BR;
        end
        ST_BR: begin
          if (is_start) begin
            state <= ST_INIT;
          end else if (region_two) begin
            state <= ST_UPD;
          end else begin
            state <= ST_CMP1;
          end
        end
        ST_INIT: begin
          // 4*ry^2 - 4*rx^2*ry + rx^2, the first decision scaled by four.
          decision   <= (DB'(ry2) << 2) - (prod_dec << 2) + DB'(rx2);
          cur_x      <= '0;
          cur_y      <= POS_BITS'(radius_y);
          region_two <= 1'b0;
          finished   <= (radius_y == '0);
          state      <= ST_GRP;
        end
        ST_CMP1: begin
          state <= ST_CMP2;
        end
        ST_CMP2: begin
          // Region 1 ends once ry^2*x exceeds rx^2*y.
          state <= (cmp_lhs > prod) ? ST_R2A : ST_UPD;
        end
        ST_R2A: begin
          state <= ST_R2B;
        end
        ST_R2B: begin
          decision <= prod_dec;
          state    <= ST_R2C;
        end
        ST_R2C: begin
          state <= ST_R2D;
        end
        ST_R2D: begin
          decision <= decision + (prod_dec << 2);
          state    <= ST_R2E;
        end
        ST_R2E: begin
          decision   <= decision - (prod_dec << 2);
          region_two <= 1'b1;
          state      <= ST_UPD;
        end
        ST_UPD: begin
          // Move the walker and note which products the increment needs.
          if (!region_two) begin
            cur_x    <= cur_x + POS_BITS'(1);
            use_ry2x <= 1'b1;
            use_rx2y <= !dec_neg;
            if (!dec_neg) begin
              cur_y <= y_dec;
            end
          end else begin
            cur_y    <= y_dec;
            use_ry2x <= !dec_pos;
            use_rx2y <= 1'b1;
            if (!dec_pos) begin
              cur_x <= cur_x + POS_BITS'(1);
            end
          end
          state <= ST_M1;
        end
        ST_M1: begin
          state <= ST_A1;
        end
        ST_A1: begin
          if (use_ry2x) begin
            decision <= decision + (prod_dec << 3);
          end
          state <= ST_A2;
        end
        ST_A2: begin
          decision <= decision - (use_rx2y ? (prod_dec << 3) : '0)
                      + ((region_two ? DB'(rx2) : DB'(ry2)) << 2);
          finished <= (cur_y == '0);
          state    <= ST_GRP;
        end
        ST_GRP: begin
          if (grp_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Datapath registers that need no reset.
  always_ff @(posedge clk) begin
    if (state == ST_SQY) begin
      rx2 <= prod[MA_BITS-1:0];
    end
    if (state == ST_BR) begin
      ry2 <= prod[MA_BITS-1:0];
    end
    if (state == ST_CMP1) begin
      cmp_lhs <= prod;
    end
  end

  assign grp_ctl.valid = (state == ST_GRP);
  assign grp_ctl.fin   = finished;

  emr_emit #(
    .RADIUS_BITS(RADIUS_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_emit (
    .clk      (clk),
    .rst      (rst),
    .grp_ctl  (grp_ctl),
    .grp_x    (cur_x),
    .grp_y    (cur_y),
    .center_x (center_x),
    .center_y (center_y),
    .grp_ready(grp_ready),
    .pix      (pix)
  );

  // An advance on a finished ellipse must not start the sequencer.
  assert property (@(posedge clk) disable iff (rst)
    (cmd_fire && !cmd.start_req && finished) |=> (state == ST_IDLE))
    else $error("advance after the end started a step");

  // A point marked as the last one of the ellipse sits on the x axis.
  assert property (@(posedge clk) disable iff (rst)
    (grp_ctl.valid && grp_ctl.fin) |-> (cur_y == '0))
    else $error("finished point with nonzero y");

  // Only a start leaves region 2.
  assert property (@(posedge clk) disable iff (rst)
    $fell(region_two) |-> ($past(state) == ST_INIT))
    else $error("region 2 left without a start");

  // The region change always lands in region 2 before the step.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_R2E) |=> (region_two && state == ST_UPD))
    else $error("region change did not take effect");

endmodule

// ===== sim/midpoint_ellipse_raster_tb.sv =====
// Self-checking testbench for midpoint_ellipse_raster: drives configuration
// writes and start/advance requests, predicts every pixel and checks it.
// Depends on emr_pkg, emr_cmd_if, emr_pix_if, emr_cfg_if and the block itself.
`timescale 1ns / 100ps

module midpoint_ellipse_raster_tb;

  // Cycle budget for the whole run, far above what a correct run needs even
  // with the heaviest stalling, so this only trips on a hang.
  localparam int CYCLE_LIMIT = 200000;
  // Pause after a request that produces no pixels, so that the block has
  // finished with it before the next register write.
  localparam int QUIET_CYCLES = 30;
  localparam int ITEMS_PER_PHASE = 18;

  typedef struct packed {
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic               last_pix;
    logic               fin;
  } pixel_t;

  // Scoreboard: keeps its own copy of the registers and the walker state,
  // and turns every accepted request into the pixels it must produce.
  class ellipse_checker;
    logic [11:0] center_x, center_y;
    logic [9:0]  radius_x, radius_y;
    logic [10:0] walk_x, walk_y;
    longint      decision;
    bit          region_two, finished;
    pixel_t      expected_pixels[$];
    int          errors;
    int          last_count;

    function new();
      center_x = '0;
      center_y = '0;
      radius_x = '0;
      radius_y = '0;
      walk_x = '0;
      walk_y = '0;
      decision = 0;
      region_two = 0;
      finished = 1;
      errors = 0;
      last_count = 0;
    endfunction

    function void write_reg(logic [emr_pkg::CFG_IDX_BITS-1:0] idx, logic [11:0] data);
      case (idx)
        emr_pkg::CFG_CENTER_X: center_x = data;
        emr_pkg::CFG_CENTER_Y: center_y = data;
        emr_pkg::CFG_RADIUS_X: radius_x = data[9:0];
        emr_pkg::CFG_RADIUS_Y: radius_y = data[9:0];
        default: ;
      endcase
    endfunction

    // Keep 48 bits, sign-extended, as the hardware decision register does.
    function longint wrap48(longint v);
      longint t;
      t = v <<< 16;
      return t >>> 16;
    endfunction

    // Four mirrored pixels in the order (+x,+y), (+x,-y), (-x,+y), (-x,-y).
    function void push_group();
      longint cx, cy, x, y;
      pixel_t p;
      cx = $signed(center_x);
      cy = $signed(center_y);
      x = walk_x;
      y = walk_y;
      for (int k = 0; k < 4; k++) begin
        p.px = (k < 2) ? 13'(cx + x) : 13'(cx - x);
        p.py = (k % 2 == 0) ? 13'(cy + y) : 13'(cy - y);
        p.last_pix = (k == 3);
        p.fin = finished;
        expected_pixels.push_back(p);
      end
      last_count = 4;
    endfunction

    function void note_request(bit start);
      longint rx, ry, rx2, ry2, x, y;
      rx = radius_x;
      ry = radius_y;
      rx2 = rx * rx;
      ry2 = ry * ry;
      last_count = 0;
      if (start) begin
        walk_x = '0;
        walk_y = 11'(ry);
        region_two = 0;
        decision = wrap48(4 * ry2 - 4 * rx2 * ry + rx2);
        finished = (walk_y == 0);
        push_group();
        return;
      end
      // Advancing past the end leaves everything as it is.
      if (finished) return;
      x = walk_x;
      y = walk_y;
      // Crossing into region 2 reloads the decision and steps at once.
      if (!region_two && ry2 * x > rx2 * y) begin
        region_two = 1;
        decision = wrap48(ry2 * (2 * x + 1) * (2 * x + 1)
                          + 4 * rx2 * (y - 1) * (y - 1) - 4 * rx2 * ry2);
      end
      if (!region_two) begin
        x = x + 1;
        if (decision < 0) begin
          decision = wrap48(decision + 4 * (2 * ry2 * x + ry2));
        end else begin
          y = y - 1;
          decision = wrap48(decision + 4 * (2 * ry2 * x - 2 * rx2 * y + ry2));
        end
      end else begin
        y = y - 1;
        if (decision <= 0) begin
          x = x + 1;
          decision = wrap48(decision + 4 * (2 * ry2 * x - 2 * rx2 * y + rx2));
        end else begin
          decision = wrap48(decision + 4 * (rx2 - 2 * rx2 * y));
        end
      end
      walk_x = 11'(x);
      walk_y = 11'(y);
      finished = (walk_y == 0);
      push_group();
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (expected_pixels.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b done=%0b", $time,
                 got.px, got.py, got.last_pix, got.fin);
        return;
      end
      want = expected_pixels.pop_front();
      if (got !== want) begin
        errors++;
        $display("%0t: pixel mismatch, expected x=%0d y=%0d last=%0b done=%0b,",
                 $time, want.px, want.py, want.last_pix, want.fin);
        $display("%0t:                actual   x=%0d y=%0d last=%0b done=%0b",
                 $time, got.px, got.py, got.last_pix, got.fin);
      end
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;
  int   send_idle;   // percent of cycles the request side holds back
  int   stall_pct;   // percent of cycles the pixel side refuses a pixel
  ellipse_checker sb;

  emr_cfg_if cfg_ch ();
  emr_cmd_if cmd_ch ();
  emr_pix_if pix_ch ();

  midpoint_ellipse_raster uut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .pix (pix_ch)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[midpoint_ellipse_raster] ERROR");
      $finish;
    end
  end

  // The pixel side stalls at random; with stall_pct at zero it never does.
  always @(negedge clk) begin
    pix_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Every pixel taken at a rising edge goes straight to the scoreboard.
  // Values read here are the ones from before the edge's updates.
  always @(posedge clk) begin
    if (!rst && pix_ch.valid && pix_ch.ready) begin
      sb.check_pixel({pix_ch.pixel_x, pix_ch.pixel_y, pix_ch.last, pix_ch.done_res});
    end
  end

  // All driving tasks start and end just after a falling edge. A request
  // leaves valid high on exit, so that a following request keeps it high
  // without a drop inside the same time step.
  task automatic send_req(input bit start);
    while ($urandom_range(99) < send_idle) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.start_req <= start;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.note_request(start);
    @(negedge clk);
  endtask

  task automatic send_cfg(input logic [emr_pkg::CFG_IDX_BITS-1:0] idx,
                          input logic [11:0] data);
    while ($urandom_range(99) < send_idle) begin
      cfg_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.write_reg(idx, data);
    @(negedge clk);
  endtask

  // Writes the registers selected by mask, in index order, then releases the
  // write channel. Only called while the block is idle.
  task automatic write_regs(input bit [3:0] mask, input logic [11:0] cx,
                            input logic [11:0] cy, input logic [11:0] rx,
                            input logic [11:0] ry);
    if (mask[emr_pkg::CFG_CENTER_X]) send_cfg(emr_pkg::CFG_CENTER_X, cx);
    if (mask[emr_pkg::CFG_CENTER_Y]) send_cfg(emr_pkg::CFG_CENTER_Y, cy);
    if (mask[emr_pkg::CFG_RADIUS_X]) send_cfg(emr_pkg::CFG_RADIUS_X, rx);
    if (mask[emr_pkg::CFG_RADIUS_Y]) send_cfg(emr_pkg::CFG_RADIUS_Y, ry);
    cfg_ch.valid <= 1'b0;
  endtask

  // Waits until every predicted pixel has come back. When the last request
  // produced nothing, the block may still be busy with it, so allow a quiet
  // stretch before the caller touches the registers.
  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    if (sb.last_count == 0) repeat (QUIET_CYCLES) @(negedge clk);
  endtask

  initial begin
    int          items;
    int          steps;
    bit          wide;
    bit          restart;
    bit [3:0]    mask;
    logic [11:0] cx, cy, rx, ry;

    sb = new();
    cycles = 0;
    send_idle = 0;
    stall_pct = 0;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.start_req = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    pix_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. Right after reset there is nothing to draw, so an
    // advance must come back empty.
    send_req(1'b0);
    drain();

    // Flat ellipse (no vertical radius): the start group is already final
    // and a following advance yields nothing. Centers at their extremes.
    write_regs(4'b1111, 12'sd2047, -12'sd2048, 12'd5, 12'd0);
    send_req(1'b1);
    send_req(1'b0);
    drain();

    // Small ellipse walked to the end without leaving region 1, plus four
    // advances past the end.
    write_regs(4'b1111, -12'sd2048, 12'sd2047, 12'd3, 12'd2);
    send_req(1'b1);
    repeat (7) send_req(1'b0);
    drain();

    // Largest radii on both axes, a few steps only.
    write_regs(4'b1111, 12'd0, 12'd0, 12'd1023, 12'd1023);
    send_req(1'b1);
    repeat (3) send_req(1'b0);
    drain();

    // No horizontal radius: a degenerate ellipse walked to its end and one step past it.
    write_regs(4'b1111, 12'd100, -12'sd100, 12'd0, 12'd3);
    send_req(1'b1);
    repeat (4) send_req(1'b0);
    drain();

    // Random part, one phase per idling pattern. Most sessions configure a
    // small ellipse and walk it to the end and a little past it. Some use
    // large radii and stop early, some change one register and carry on
    // from where the walker stands, and a few restarts are mixed in.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle = 0;  stall_pct = 0;  end
        1: begin send_idle = 77; stall_pct = 0;  end
        2: begin send_idle = 0;  stall_pct = 77; end
        default: begin send_idle = 13; stall_pct = 13; end
      endcase
      items = 0;
      while (items < ITEMS_PER_PHASE) begin
        wide = ($urandom_range(99) < 12);
        cx = 12'($urandom_range(4095));
        cy = 12'($urandom_range(4095));
        if (wide) begin
          rx = ($urandom_range(3) == 0) ? 12'd1023 : 12'($urandom_range(1023));
          ry = ($urandom_range(3) == 0) ? 12'd1023 : 12'($urandom_range(1023));
        end else begin
          rx = 12'($urandom_range(10));
          ry = 12'($urandom_range(10));
        end
        if (items == 0 || $urandom_range(99) >= 20) begin
          mask = 4'b1111;
          restart = 1'b1;
        end else begin
          mask = 4'b0001 << $urandom_range(3);
          restart = 1'b0;
        end
        steps = (wide || !restart) ? $urandom_range(2, 8)
                                   : rx + ry + $urandom_range(0, 2);
        write_regs(mask, cx, cy, rx, ry);
        if (restart) send_req(1'b1);
        for (int k = 0; k < steps; k++) send_req($urandom_range(99) < 4);
        items += steps + restart;
        drain();
      end
    end

    // Wind down: everything predicted must have arrived, and nothing more
    // may show up afterwards.
    while (sb.pending() != 0) @(negedge clk);
    repeat (QUIET_CYCLES + 10) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[midpoint_ellipse_raster] OK");
    end else begin
      $display("[midpoint_ellipse_raster] ERROR");
    end
    $finish;
  end

endmodule
